>>> rtl/tlwbc_pkg.sv
// ============================================================================
// tlwbc_pkg
// Shared widths, codes and bundle types of the two-level write-back cache.
// ============================================================================
package tlwbc_pkg;

    localparam int ADDR_W   = 16;
    localparam int WORD_W   = 32;
    localparam int OFF_W    = 4;                 // word within a 16-word block
    localparam int LINE_W   = 8;                 // L1 line index, also the L2 set
    localparam int TAG_W    = 2;
    localparam int BLK_W    = LINE_W + TAG_W;    // memory block number
    localparam int WPB      = 1 << OFF_W;
    localparam int CNT_W    = OFF_W + 1;         // copy counter, holds WPB itself
    localparam int L1D_AW   = LINE_W + OFF_W;
    localparam int L2D_AW   = LINE_W + 1 + OFF_W;
    localparam int MEM_AW   = BLK_W + OFF_W;
    localparam int COST_W   = 11;
    localparam int CFG_W    = 8;
    localparam int CIDX_W   = 3;
    localparam int LVL_W    = 2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_L1_RD  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_L1_WR  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_L2_RD  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_L2_WR  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_MEM_RD = 3'd4;
    localparam logic [CIDX_W-1:0] REG_MEM_WR = 3'd5;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // level that supplied the block
    localparam logic [LVL_W-1:0] LVL_L1  = 2'd0;
    localparam logic [LVL_W-1:0] LVL_L2  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_MEM = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] l1_rd;
        logic [CFG_W-1:0] l1_wr;
        logic [CFG_W-1:0] l2_rd;
        logic [CFG_W-1:0] l2_wr;
        logic [CFG_W-1:0] mem_rd;
        logic [CFG_W-1:0] mem_wr;
    } cost_cfg_t;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } line_meta_t;

    typedef struct packed {
        logic                  lru;
        line_meta_t [1:0]      ways;
    } set_meta_t;

    typedef struct packed {
        logic              l1_we;
        logic [L1D_AW-1:0] l1_waddr;
        logic [WORD_W-1:0] l1_wdata;
        logic [L1D_AW-1:0] l1_raddr;
        logic              l2_we;
        logic [L2D_AW-1:0] l2_waddr;
        logic [WORD_W-1:0] l2_wdata;
        logic [L2D_AW-1:0] l2_raddr;
        logic              mem_we;
        logic [MEM_AW-1:0] mem_waddr;
        logic [WORD_W-1:0] mem_wdata;
        logic [MEM_AW-1:0] mem_raddr;
        logic              vb_we;
        logic [OFF_W-1:0]  vb_waddr;
        logic [WORD_W-1:0] vb_wdata;
        logic [OFF_W-1:0]  vb_raddr;
    } data_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] l1_rdata;
        logic [WORD_W-1:0] l2_rdata;
        logic [WORD_W-1:0] mem_rdata;
        logic [WORD_W-1:0] vb_rdata;
    } data_rsp_t;

    typedef struct packed {
        logic [COST_W-1:0] access_cost;
        logic              victim_written_back;
        logic [LVL_W-1:0]  hit_level;
        logic [WORD_W-1:0] read_word;
    } result_t;

endpackage

>>> rtl/tlwbc_data.sv
// ============================================================================
// tlwbc_data
// Word-wide data stores: L1 lines, L2 ways, backing memory, victim buffer.
// ============================================================================
module tlwbc_data (
    input  logic                 aclk,
    input  tlwbc_pkg::data_req_t req,
    output tlwbc_pkg::data_rsp_t rsp
);

    logic [tlwbc_pkg::WORD_W-1:0] l1_mem  [1 << tlwbc_pkg::L1D_AW];
    logic [tlwbc_pkg::WORD_W-1:0] l2_mem  [1 << tlwbc_pkg::L2D_AW];
    logic [tlwbc_pkg::WORD_W-1:0] bk_mem  [1 << tlwbc_pkg::MEM_AW];
    logic [tlwbc_pkg::WORD_W-1:0] vb_mem  [tlwbc_pkg::WPB];

    always_ff @(posedge aclk) begin
        if (req.l1_we) begin
            l1_mem[req.l1_waddr] <= req.l1_wdata;
        end
        rsp.l1_rdata <= l1_mem[req.l1_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.l2_we) begin
            l2_mem[req.l2_waddr] <= req.l2_wdata;
        end
        rsp.l2_rdata <= l2_mem[req.l2_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.mem_we) begin
            bk_mem[req.mem_waddr] <= req.mem_wdata;
        end
        rsp.mem_rdata <= bk_mem[req.mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.vb_we) begin
            vb_mem[req.vb_waddr] <= req.vb_wdata;
        end
        rsp.vb_rdata <= vb_mem[req.vb_raddr];
    end

endmodule

>>> rtl/tlwbc_ctrl.sv
// ============================================================================
// tlwbc_ctrl
// Access sequencer: tag stores, lookups, block copies and cost tally.
// ============================================================================
module tlwbc_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_op,
    input  logic [tlwbc_pkg::ADDR_W-1:0]      in_addr,
    input  logic [tlwbc_pkg::WORD_W-1:0]      in_wdata,
    input  tlwbc_pkg::cost_cfg_t              cfg,
    input  logic                              out_free,
    output logic                              done,
    output tlwbc_pkg::result_t                res,
    output tlwbc_pkg::data_req_t              req,
    input  tlwbc_pkg::data_rsp_t              rsp
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_META   = 4'd2;
    localparam logic [3:0] ST_HITRD  = 4'd3;
    localparam logic [3:0] ST_VCOPY  = 4'd4;
    localparam logic [3:0] ST_L2LOOK = 4'd5;
    localparam logic [3:0] ST_L2WB   = 4'd6;
    localparam logic [3:0] ST_MFILL  = 4'd7;
    localparam logic [3:0] ST_L2FILL = 4'd8;
    localparam logic [3:0] ST_OPDONE = 4'd9;
    localparam logic [3:0] ST_VLOOK  = 4'd10;
    localparam logic [3:0] ST_VWB    = 4'd11;
    localparam logic [3:0] ST_VSTORE = 4'd12;
    localparam logic [3:0] ST_FIN    = 4'd13;

    tlwbc_pkg::line_meta_t l1_meta_mem [1 << tlwbc_pkg::LINE_W];
    tlwbc_pkg::set_meta_t  l2_meta_mem [1 << tlwbc_pkg::LINE_W];
    tlwbc_pkg::line_meta_t l1m_rd;
    tlwbc_pkg::set_meta_t  l2m_rd;

    logic [3:0]                    state_reg,  state_next;
    logic [tlwbc_pkg::MEM_AW-1:0]  clr_reg,    clr_next;
    logic [tlwbc_pkg::CNT_W-1:0]   cnt_reg,    cnt_next;
    logic                          op_reg,     op_next;
    logic [tlwbc_pkg::BLK_W-1:0]   blk_reg,    blk_next;
    logic [tlwbc_pkg::OFF_W-1:0]   off_reg,    off_next;
    logic [tlwbc_pkg::WORD_W-1:0]  wdata_reg,  wdata_next;
    logic [tlwbc_pkg::WORD_W-1:0]  rd_reg,     rd_next;
    logic [tlwbc_pkg::LVL_W-1:0]   level_reg,  level_next;
    logic                          victim_reg, victim_next;
    logic [tlwbc_pkg::TAG_W-1:0]   vtag_reg,   vtag_next;
    logic [tlwbc_pkg::TAG_W-1:0]   wbtag_reg,  wbtag_next;
    logic                          way_reg,    way_next;
    logic [tlwbc_pkg::COST_W-1:0]  cost_reg,   cost_next;
    tlwbc_pkg::line_meta_t         l1m_reg,    l1m_next;
    tlwbc_pkg::set_meta_t          l2m_reg,    l2m_next;

    logic [tlwbc_pkg::LINE_W-1:0]  line;
    logic [tlwbc_pkg::TAG_W-1:0]   tag;
    logic [tlwbc_pkg::OFF_W-1:0]   rd_idx;
    logic [tlwbc_pkg::OFF_W-1:0]   wr_idx;
    logic [tlwbc_pkg::CNT_W-1:0]   cnt_dec;
    logic                          copy_wr;
    logic                          copy_last;
    logic [tlwbc_pkg::LINE_W-1:0]  in_line;

    assign line      = blk_reg[tlwbc_pkg::LINE_W-1:0];
    assign tag       = blk_reg[tlwbc_pkg::BLK_W-1:tlwbc_pkg::LINE_W];
    assign rd_idx    = cnt_reg[tlwbc_pkg::OFF_W-1:0];
    assign cnt_dec   = cnt_reg - tlwbc_pkg::CNT_W'(1);
    assign wr_idx    = cnt_dec[tlwbc_pkg::OFF_W-1:0];
    assign copy_wr   = (cnt_reg != '0);
    assign copy_last = (cnt_reg == tlwbc_pkg::CNT_W'(tlwbc_pkg::WPB));
    assign in_line   = in_addr[tlwbc_pkg::OFF_W+2+tlwbc_pkg::LINE_W-1:tlwbc_pkg::OFF_W+2];

    assign in_ready  = (state_reg == ST_IDLE);

    assign res.read_word           = rd_reg;
    assign res.hit_level           = level_reg;
    assign res.victim_written_back = victim_reg;
    assign res.access_cost         = cost_reg;

    function automatic logic [tlwbc_pkg::COST_W-1:0] add_cost(
        input logic [tlwbc_pkg::COST_W-1:0] acc,
        input logic [tlwbc_pkg::CFG_W-1:0]  amt
    );
        return tlwbc_pkg::COST_W'(acc + tlwbc_pkg::COST_W'(amt));
    endfunction

    // tag stores: read at the incoming line every cycle, written back at finish
    always_ff @(posedge aclk) begin
        l1m_rd <= l1_meta_mem[in_line];
        if (state_reg == ST_CLEAR) begin
            l1_meta_mem[clr_reg[tlwbc_pkg::LINE_W-1:0]] <= '0;
        end else if (state_reg == ST_FIN) begin
            l1_meta_mem[line] <= l1m_reg;
        end
    end

    always_ff @(posedge aclk) begin
        l2m_rd <= l2_meta_mem[in_line];
        if (state_reg == ST_CLEAR) begin
            l2_meta_mem[clr_reg[tlwbc_pkg::LINE_W-1:0]] <= '0;
        end else if (state_reg == ST_FIN) begin
            l2_meta_mem[line] <= l2m_reg;
        end
    end

    always_comb begin
        logic                         w;
        logic                         hit0;
        logic                         hit1;
        logic [tlwbc_pkg::WORD_W-1:0] src;

        state_next  = state_reg;
        clr_next    = clr_reg;
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        blk_next    = blk_reg;
        off_next    = off_reg;
        wdata_next  = wdata_reg;
        rd_next     = rd_reg;
        level_next  = level_reg;
        victim_next = victim_reg;
        vtag_next   = vtag_reg;
        wbtag_next  = wbtag_reg;
        way_next    = way_reg;
        cost_next   = cost_reg;
        l1m_next    = l1m_reg;
        l2m_next    = l2m_reg;
        done        = 1'b0;
        req         = '0;
        w           = 1'b0;
        hit0        = 1'b0;
        hit1        = 1'b0;
        src         = (state_reg == ST_MFILL) ? rsp.mem_rdata : rsp.l2_rdata;

        unique case (state_reg)
            ST_CLEAR: begin
                // zero the backing memory; tag stores follow the low counter bits
                req.mem_we    = 1'b1;
                req.mem_waddr = clr_reg;
                clr_next      = clr_reg + tlwbc_pkg::MEM_AW'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    op_next     = in_op;
                    blk_next    = in_addr[tlwbc_pkg::ADDR_W-1:tlwbc_pkg::OFF_W+2];
                    off_next    = in_addr[tlwbc_pkg::OFF_W+1:2];
                    wdata_next  = in_wdata;
                    rd_next     = '0;
                    level_next  = tlwbc_pkg::LVL_L1;
                    victim_next = 1'b0;
                    cost_next   = '0;
                    state_next  = ST_META;
                end
            end
            ST_META: begin
                l1m_next = l1m_rd;
                l2m_next = l2m_rd;
                if (l1m_rd.valid && (l1m_rd.tag == tag)) begin
                    if (op_reg == tlwbc_pkg::OP_WRITE) begin
                        req.l1_we      = 1'b1;
                        req.l1_waddr   = {line, off_reg};
                        req.l1_wdata   = wdata_reg;
                        l1m_next.dirty = 1'b1;
                        cost_next      = add_cost(cost_reg, cfg.l1_wr);
                        state_next     = ST_FIN;
                    end else begin
                        req.l1_raddr   = {line, off_reg};
                        cost_next      = add_cost(cost_reg, cfg.l1_rd);
                        state_next     = ST_HITRD;
                    end
                end else begin
                    victim_next = l1m_rd.valid && l1m_rd.dirty;
                    vtag_next   = l1m_rd.tag;
                    l1m_next    = '{valid: 1'b1, dirty: 1'b0, tag: tag};
                    cnt_next    = '0;
                    state_next  = (l1m_rd.valid && l1m_rd.dirty) ? ST_VCOPY : ST_L2LOOK;
                end
            end
            ST_HITRD: begin
                rd_next    = rsp.l1_rdata;
                state_next = ST_FIN;
            end
            ST_VCOPY: begin
                req.l1_raddr = {line, rd_idx};
                req.vb_we    = copy_wr;
                req.vb_waddr = wr_idx;
                req.vb_wdata = rsp.l1_rdata;
                cnt_next     = cnt_reg + tlwbc_pkg::CNT_W'(1);
                if (copy_last) begin
                    state_next = ST_L2LOOK;
                end
            end
            ST_L2LOOK: begin
                hit0      = l2m_reg.ways[0].valid && (l2m_reg.ways[0].tag == tag);
                hit1      = l2m_reg.ways[1].valid && (l2m_reg.ways[1].tag == tag);
                cost_next = add_cost(cost_reg, cfg.l2_rd);
                cnt_next  = '0;
                if (hit0 || hit1) begin
                    w            = !hit0;
                    way_next     = w;
                    l2m_next.lru = !w;
                    level_next   = tlwbc_pkg::LVL_L2;
                    state_next   = ST_L2FILL;
                end else begin
                    w                = l2m_reg.lru;
                    way_next         = w;
                    wbtag_next       = l2m_reg.ways[w].tag;
                    l2m_next.lru     = !w;
                    l2m_next.ways[w] = '{valid: 1'b1, dirty: 1'b0, tag: tag};
                    level_next       = tlwbc_pkg::LVL_MEM;
                    state_next       = (l2m_reg.ways[w].valid && l2m_reg.ways[w].dirty)
                                       ? ST_L2WB : ST_MFILL;
                end
            end
            ST_L2WB, ST_VWB: begin
                // drain the evicted L2 way to memory at its own block
                req.l2_raddr  = {line, way_reg, rd_idx};
                req.mem_we    = copy_wr;
                req.mem_waddr = {wbtag_reg, line, wr_idx};
                req.mem_wdata = rsp.l2_rdata;
                cnt_next      = cnt_reg + tlwbc_pkg::CNT_W'(1);
                if (copy_last) begin
                    cost_next  = add_cost(cost_reg, cfg.mem_wr);
                    cnt_next   = '0;
                    state_next = (state_reg == ST_L2WB) ? ST_MFILL : ST_VSTORE;
                end
            end
            ST_MFILL, ST_L2FILL: begin
                // stream block into L1, and L2 on MFILL, merging the write word
                if (state_reg == ST_MFILL) begin
                    req.mem_raddr = {blk_reg, rd_idx};
                    req.l2_we     = copy_wr;
                    req.l2_waddr  = {line, way_reg, wr_idx};
                    req.l2_wdata  = rsp.mem_rdata;
                end else begin
                    req.l2_raddr  = {line, way_reg, rd_idx};
                end
                req.l1_we    = copy_wr;
                req.l1_waddr = {line, wr_idx};
                req.l1_wdata = (wr_idx == off_reg && op_reg == tlwbc_pkg::OP_WRITE)
                               ? wdata_reg : src;
                if (copy_wr && wr_idx == off_reg && op_reg == tlwbc_pkg::OP_READ) begin
                    rd_next = src;
                end
                cnt_next = cnt_reg + tlwbc_pkg::CNT_W'(1);
                if (copy_last) begin
                    if (state_reg == ST_MFILL) begin
                        cost_next = add_cost(cost_reg, cfg.mem_rd);
                    end
                    state_next = ST_OPDONE;
                end
            end
            ST_OPDONE: begin
                if (op_reg == tlwbc_pkg::OP_WRITE) begin
                    l1m_next.dirty = 1'b1;
                    cost_next      = add_cost(cost_reg, cfg.l1_wr);
                end else begin
                    cost_next      = add_cost(cost_reg, cfg.l1_rd);
                end
                state_next = victim_reg ? ST_VLOOK : ST_FIN;
            end
            ST_VLOOK: begin
                hit0      = l2m_reg.ways[0].valid && (l2m_reg.ways[0].tag == vtag_reg);
                hit1      = l2m_reg.ways[1].valid && (l2m_reg.ways[1].tag == vtag_reg);
                cost_next = add_cost(cost_reg, cfg.l2_wr);
                cnt_next  = '0;
                if (hit0 || hit1) begin
                    w                      = !hit0;
                    way_next               = w;
                    l2m_next.lru           = !w;
                    l2m_next.ways[w].dirty = 1'b1;
                    state_next             = ST_VSTORE;
                end else begin
                    w                = l2m_reg.lru;
                    way_next         = w;
                    wbtag_next       = l2m_reg.ways[w].tag;
                    l2m_next.lru     = !w;
                    l2m_next.ways[w] = '{valid: 1'b1, dirty: 1'b1, tag: vtag_reg};
                    state_next       = (l2m_reg.ways[w].valid && l2m_reg.ways[w].dirty)
                                       ? ST_VWB : ST_VSTORE;
                end
            end
            ST_VSTORE: begin
                req.vb_raddr = rd_idx;
                req.l2_we    = copy_wr;
                req.l2_waddr = {line, way_reg, wr_idx};
                req.l2_wdata = rsp.vb_rdata;
                cnt_next     = cnt_reg + tlwbc_pkg::CNT_W'(1);
                if (copy_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                done = out_free;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        blk_reg    <= blk_next;
        off_reg    <= off_next;
        wdata_reg  <= wdata_next;
        rd_reg     <= rd_next;
        level_reg  <= level_next;
        victim_reg <= victim_next;
        vtag_reg   <= vtag_next;
        wbtag_reg  <= wbtag_next;
        way_reg    <= way_next;
        cost_reg   <= cost_next;
        l1m_reg    <= l1m_next;
        l2m_reg    <= l2m_next;
    end

endmodule

>>> rtl/two_level_write_back_cache_top.sv
// ============================================================================
// two_level_write_back_cache_top
// Word access through a direct-mapped L1 and a two-way LRU L2 over a memory.
// ============================================================================
// One item at a time. After reset the block zeroes its 16384-word backing
// memory and tag stores, one word a cycle, and holds s_tready low until the
// sweep ends; cost registers can be written meanwhile. An L1 read hit passes
// through tag read, data read and finish before its result shows, an L1 write
// hit through tag read and finish. Each 16-word block move between word-wide
// stores runs on one copy sequencer: a miss fills from L2 or from memory, a
// fill from memory first writes back a dirty L2 eviction if there is one, and
// a dirty L1 victim adds its buffer copy, its L2 lookup, its store into L2 and
// possibly one more L2 eviction. The block is ready for the next item in the
// same cycle that the result sits in the output register; a stalled result
// holds the block.
// ============================================================================
module two_level_write_back_cache_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input transfer
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,  // [15:0] byte_address, [47:16] write_word
    input  logic                            s_tuser,  // [0] op
    // result transfer
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,  // [31:0] read_word, [33:32] hit_level,
                                                      // [34] victim_written_back,
                                                      // [45:35] access_cost, rest zero
    // cost registers
    input  logic                            cfg_we,
    input  logic [tlwbc_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [tlwbc_pkg::CFG_W-1:0]     cfg_wdata
);

    tlwbc_pkg::cost_cfg_t cfg_reg;
    tlwbc_pkg::data_req_t req;
    tlwbc_pkg::data_rsp_t rsp;
    tlwbc_pkg::result_t   res;
    logic                 done;
    logic                 out_free;
    logic                 m_tvalid_reg;
    logic [47:0]          m_tdata_reg;

    // cost registers; writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.l1_rd  <= 8'd1;
            cfg_reg.l1_wr  <= 8'd1;
            cfg_reg.l2_rd  <= 8'd10;
            cfg_reg.l2_wr  <= 8'd5;
            cfg_reg.mem_rd <= 8'd100;
            cfg_reg.mem_wr <= 8'd50;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tlwbc_pkg::REG_L1_RD:  cfg_reg.l1_rd  <= cfg_wdata;
                tlwbc_pkg::REG_L1_WR:  cfg_reg.l1_wr  <= cfg_wdata;
                tlwbc_pkg::REG_L2_RD:  cfg_reg.l2_rd  <= cfg_wdata;
                tlwbc_pkg::REG_L2_WR:  cfg_reg.l2_wr  <= cfg_wdata;
                tlwbc_pkg::REG_MEM_RD: cfg_reg.mem_rd <= cfg_wdata;
                tlwbc_pkg::REG_MEM_WR: cfg_reg.mem_wr <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tlwbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_addr  (s_tdata[15:0]),
        .in_wdata (s_tdata[47:16]),
        .cfg      (cfg_reg),
        .out_free (out_free),
        .done     (done),
        .res      (res),
        .req      (req),
        .rsp      (rsp)
    );

    tlwbc_data u_data (
        .aclk (aclk),
        .req  (req),
        .rsp  (rsp)
    );

    // output register: hold the result until the transfer completes
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_tdata_reg <= {2'b00, res.access_cost, res.victim_written_back,
                            res.hit_level, res.read_word};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/tlwbc_chk.sv
// ============================================================================
// tlwbc_chk
// Port-level checks of the cache block, bound to the top level.
// ============================================================================
module tlwbc_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [47:0]                   m_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: a transfer in drops ready next cycle
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in flight");

    // level code is one of three
    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[33:32] != 2'd3)
        else $error("bad hit level");

    // a victim exists only on an L1 miss
    a_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> m_tdata[33:32] != tlwbc_pkg::LVL_L1)
        else $error("victim reported on an L1 hit");

endmodule

bind two_level_write_back_cache_top tlwbc_chk u_chk (.*);
